FILE: rtl/rna_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational ALU package
// Shared payload types, action codes, status codes and the command/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package rna_pkg;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_NEG = 3'd4,
    ACT_CMP = 3'd5
  } action_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    logic               less;
    logic               equal;
    logic               greater;
    logic [1:0]         status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture operands, check errors
    logic mul1;      // first product pair
    logic mul2;      // second product pair, form num/den
    logic gcd_init;  // start gcd
    logic gcd_step;  // one binary gcd step
    logic div_init;  // start division by gcd
    logic div_step;  // one restoring division step
    logic finish;    // form the result item
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic err;       // result decided at load
    logic is_cmp;
    logic gcd_done;
    logic div_done;
  } dp_sts_t;

endpackage

FILE: rtl/rational_number_alu_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational number ALU, top level
// Add, subtract, multiply, divide, negate or compare two fractions, with the
// result reduced by its gcd and a positive denominator.
// ----------------------------------------------------------------------------
// One item at a time. A transfer is taken when start is high and busy low;
// busy then stays high through the result strobe cycle and drops the cycle
// after, when the next transfer can be taken. Compare and error items go
// straight from the products to the result; arithmetic items first run the
// binary gcd, one step per cycle, where every step drops at least one bit
// from the two operands, and then the 65-step bit-serial division by the
// gcd. out_valid is high for exactly one cycle and the receiver cannot
// stall it: the result must be taken in that cycle.
// ----------------------------------------------------------------------------
module rational_number_alu_top #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rna_pkg::in_item_t   in_item,
  output logic                out_valid,
  output rna_pkg::out_item_t  out_item
);

  rna_pkg::dp_cmd_t cmd;
  rna_pkg::dp_sts_t sts;

  // sequencer
  rna_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .out_valid, .sts, .cmd
  );

  // arithmetic, gcd and divide
  rna_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk, .rst_n, .in_item, .cmd, .sts, .result(out_item)
  );

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("transfer not taken");

endmodule

FILE: rtl/rna_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational ALU datapath
// Operand registers, two 33x33 magnitude multipliers, a binary gcd unit and a
// bit-serial divider that divides numerator and denominator by the gcd.
// ----------------------------------------------------------------------------
module rna_datapath #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rna_pkg::in_item_t    in_item,
  input  rna_pkg::dp_cmd_t     cmd,
  output rna_pkg::dp_sts_t     sts,
  output rna_pkg::out_item_t   result
);

  localparam int CW = $clog2(64 + 1);

  // sign-extended operands from the low OPERAND_WIDTH bits
  function automatic logic signed [32:0] sx(input logic [31:0] v);
    logic [31:0] t;
    t = v << (32 - OPERAND_WIDTH);
    return 33'(signed'(t) >>> (32 - OPERAND_WIDTH));
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  logic [2:0]         act_r;
  logic signed [32:0] a_r, b_r, c_r, d_r;
  logic               err_r;

  // magnitude products (33x33 -> 66 but |x| <= 2^31 so 64 bits suffice)
  logic [63:0] p0_r, p1_r;        // first pair
  logic        s0_r, s1_r;
  logic [64:0] num_mag_r, den_mag_r;
  logic        num_neg_r, den_neg_r;

  logic [64:0] gx_r, gy_r;        // gcd operands
  logic [CW-1:0] gk_r;            // common factor of two
  logic        g_done_r;

  logic [64:0] g_r;               // gcd
  logic [64:0] nq_r, dq_r;        // quotients (shifted in)
  logic [64:0] nrem_r, drem_r;
  logic [64:0] nsh_r, dsh_r;      // dividend shift
  logic [6:0]  dcnt_r;

  logic        lt_r, eq_r, gt_r;
  rna_pkg::out_item_t res_r;

  // operand selection for the shared multiplier
  logic signed [32:0] mx, my;
  logic [63:0]        mprod;
  logic               mneg;

  always_comb begin
    mx = a_r;
    my = d_r;
    if (cmd.mul2) begin
      unique case (act_r)
        rna_pkg::ACT_ADD, rna_pkg::ACT_SUB, rna_pkg::ACT_MUL: begin mx = b_r; my = d_r; end
        rna_pkg::ACT_DIV: begin mx = b_r; my = c_r; end
        default: begin mx = b_r; my = 33'sd1; end
      endcase
    end else begin
      unique case (act_r)
        rna_pkg::ACT_MUL: begin mx = a_r; my = c_r; end
        rna_pkg::ACT_NEG: begin mx = a_r; my = -33'sd1; end
        default: begin mx = a_r; my = d_r; end
      endcase
    end
    mprod = 64'(mag33(mx)) * 64'(mag33(my));
    mneg  = mx[32] ^ my[32];
  end

  // second product for add/sub/cmp: b*c
  logic [63:0] bc;
  assign bc = 64'(mag33(b_r)) * 64'(mag33(c_r));

  logic        t_neg;
  logic [64:0] sum_mag;
  logic        sum_neg;
  always_comb begin
    t_neg = (b_r[32] ^ c_r[32]) ^ (act_r == rna_pkg::ACT_SUB);
    if (s0_r == t_neg) begin
      sum_neg = s0_r; sum_mag = {1'b0, p0_r} + {1'b0, p1_r};
    end else if (p0_r >= p1_r) begin
      sum_neg = s0_r; sum_mag = {1'b0, p0_r - p1_r};
    end else begin
      sum_neg = t_neg; sum_mag = {1'b0, p1_r - p0_r};
    end
  end

  // compare uses p0 = |an*bd| signed, p1 = |bn*ad| signed after denominator fix
  logic signed [65:0] lhs, rhs;
  always_comb begin
    lhs = s0_r ? -$signed({2'b0, p0_r}) : $signed({2'b0, p0_r});
    rhs = s1_r ? -$signed({2'b0, p1_r}) : $signed({2'b0, p1_r});
  end

  // binary gcd step
  logic [64:0] gx_nxt, gy_nxt;
  always_comb begin
    gx_nxt = gx_r;
    gy_nxt = gy_r;
    if (!gx_r[0] && !gy_r[0]) begin
      gx_nxt = gx_r >> 1; gy_nxt = gy_r >> 1;
    end else if (!gx_r[0]) begin
      gx_nxt = gx_r >> 1;
    end else if (!gy_r[0]) begin
      gy_nxt = gy_r >> 1;
    end else if (gx_r >= gy_r) begin
      gx_nxt = (gx_r - gy_r) >> 1;
    end else begin
      gy_nxt = (gy_r - gx_r) >> 1;
    end
  end

  // division steps
  logic [65:0] ntr, dtr;
  assign ntr = {nrem_r, nsh_r[64]};
  assign dtr = {drem_r, dsh_r[64]};

  logic [63:0] n_fin;
  logic        neg_fin, ovf;
  always_comb begin
    n_fin   = nq_r[63:0];
    neg_fin = (num_neg_r ^ den_neg_r) && (nq_r != '0);
    ovf = (dq_r > 65'h7FFF_FFFF_FFFF_FFFF) ||
          (neg_fin ? (nq_r > 65'h8000_0000_0000_0000)
                   : (nq_r >= 65'h8000_0000_0000_0000));
  end

  // result item
  rna_pkg::out_item_t res_nxt;
  always_comb begin
    res_nxt = '0;
    if (err_r) begin
      res_nxt.status = rna_pkg::ST_ZERO;
    end else if (act_r == 3'(rna_pkg::ACT_CMP)) begin
      res_nxt.less = lt_r; res_nxt.equal = eq_r; res_nxt.greater = gt_r;
    end else if (ovf) begin
      res_nxt.status = rna_pkg::ST_OVF;
    end else begin
      res_nxt.res_num = neg_fin ? 64'(-n_fin) : n_fin;
      res_nxt.res_den = dq_r[62:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_done_r <= 1'b0;
      dcnt_r   <= '0;
    end else begin
      if (cmd.load) begin
        act_r <= in_item.action;
        a_r <= sx(in_item.a_num);
        b_r <= sx(in_item.a_den);
        c_r <= sx(in_item.b_num);
        d_r <= sx(in_item.b_den);
        err_r <= (in_item.action > 3'(rna_pkg::ACT_CMP)) || (sx(in_item.a_den) == 0) ||
                 (in_item.action != 3'(rna_pkg::ACT_NEG) && sx(in_item.b_den) == 0) ||
                 (in_item.action == 3'(rna_pkg::ACT_DIV) && sx(in_item.b_num) == 0);
      end
      if (cmd.mul1) begin
        p0_r <= mprod;
        p1_r <= bc;
        if (act_r == 3'(rna_pkg::ACT_CMP)) begin
          // an*bd and bn*ad with denominators made positive
          s0_r <= (a_r[32] ^ b_r[32]) && (a_r != 0);
          s1_r <= (c_r[32] ^ d_r[32]) && (c_r != 0);
        end else begin
          s0_r <= mneg;
          s1_r <= 1'b0;
        end
      end
      if (cmd.mul2) begin
        lt_r <= lhs < rhs;
        eq_r <= lhs == rhs;
        gt_r <= lhs > rhs;
        den_mag_r <= {1'b0, mprod};
        den_neg_r <= mneg;
        if (act_r == 3'(rna_pkg::ACT_ADD) || act_r == 3'(rna_pkg::ACT_SUB)) begin
          num_mag_r <= sum_mag;
          num_neg_r <= sum_neg;
        end else begin
          num_mag_r <= {1'b0, p0_r};
          num_neg_r <= s0_r;
        end
      end
      if (cmd.gcd_init) begin
        gx_r <= num_mag_r;
        gy_r <= den_mag_r;
        gk_r <= '0;
        g_done_r <= 1'b0;
      end else if (cmd.gcd_step && !g_done_r) begin
        if (gx_r == '0 || gy_r == '0 || gx_r == gy_r) begin
          g_r <= (gx_r | gy_r) << gk_r;
          g_done_r <= 1'b1;
        end else begin
          gx_r <= gx_nxt;
          gy_r <= gy_nxt;
          if (!gx_r[0] && !gy_r[0]) gk_r <= gk_r + CW'(1);
        end
      end
      if (cmd.div_init) begin
        nsh_r <= num_mag_r; dsh_r <= den_mag_r;
        nrem_r <= '0; drem_r <= '0;
        nq_r <= '0; dq_r <= '0;
        dcnt_r <= 7'd65;
      end else if (cmd.div_step && dcnt_r != 0) begin
        nsh_r <= nsh_r << 1; dsh_r <= dsh_r << 1;
        if (ntr >= {1'b0, g_r}) begin
          nrem_r <= 65'(ntr - {1'b0, g_r}); nq_r <= {nq_r[63:0], 1'b1};
        end else begin
          nrem_r <= ntr[64:0]; nq_r <= {nq_r[63:0], 1'b0};
        end
        if (dtr >= {1'b0, g_r}) begin
          drem_r <= 65'(dtr - {1'b0, g_r}); dq_r <= {dq_r[63:0], 1'b1};
        end else begin
          drem_r <= dtr[64:0]; dq_r <= {dq_r[63:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 7'd1;
      end
      if (cmd.finish) begin
        res_r <= res_nxt;
      end
    end
  end

  assign sts.err      = err_r;
  assign sts.is_cmp   = (act_r == 3'(rna_pkg::ACT_CMP));
  assign sts.gcd_done = g_done_r;
  assign sts.div_done = (dcnt_r == 0);
  assign result       = res_r;

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(g_done_r) && !err_r && act_r != 3'(rna_pkg::ACT_CMP) |-> g_r != '0)
    else $error("gcd zero");
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |=> dcnt_r == 7'd65)
    else $error("divider not armed");
  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.mul2) && act_r == 3'(rna_pkg::ACT_CMP) |-> $onehot({lt_r, eq_r, gt_r}))
    else $error("compare flags");

endmodule

FILE: rtl/rna_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational ALU controller
// Sequences load, products, gcd, division and result strobe.
// ----------------------------------------------------------------------------
module rna_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  input  rna_pkg::dp_sts_t   sts,
  output rna_pkg::dp_cmd_t   cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL1 = 8'b0000_0010,
    S_MUL2 = 8'b0000_0100,
    S_GINI = 8'b0000_1000,
    S_GCD  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = start;
        if (start) state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = (sts.err || sts.is_cmp) ? S_FIN : S_GINI;
      end
      S_GINI: begin
        cmd.gcd_init = 1'b1;
        state_nxt = S_GCD;
      end
      S_GCD: begin
        cmd.gcd_step = 1'b1;
        if (sts.gcd_done) begin
          cmd.div_init = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe longer than one cycle");

endmodule
